// ----- sv/demand_paging_translator_unit_defines.svh -----
// Assertion macros shared by the demand paging translator RTL.
// Included by the top level; depends on nothing else.
`ifndef DEMAND_PAGING_TRANSLATOR_UNIT_DEFINES_SVH
`define DEMAND_PAGING_TRANSLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("demand paging translator: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("demand paging translator: next-cycle check failed");

`endif

// ----- sv/dpt_pkg.sv -----
// Shared types and constants of the demand paging translator.
// Used by the controller, the datapath and the top level.
`default_nettype none

package dpt_pkg;

    localparam int FRAMES_DEF  = 64;
    localparam int ADDR_W      = 32;
    localparam int OFFSET_BITS = 12;
    localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
    localparam int TICK_W      = 32;
    localparam int FIU_W       = 7;
    localparam int FRAME_OUT_W = 6;
    localparam int PHYS_W      = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int REGIONS     = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [FIU_W-1:0]  FIU_RESET = FIU_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION0_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION0_END  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION1_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION1_END  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REGION2_BASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REGION2_END  = 3'd7;

    typedef struct packed {
        logic accept;
        logic check;
        logic scan;
        logic commit;
    } dpt_cmd_t;

    typedef struct packed {
        logic in_range;
        logic scan_done;
        logic out_free;
    } dpt_sts_t;

endpackage

`default_nettype wire

// ----- sv/dpt_ctrl.sv -----
// Sequencing state machine of the demand paging translator.
// Depends on dpt_pkg for the command and status structs.
`default_nettype none

module dpt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dpt_pkg::dpt_sts_t sts,
    output dpt_pkg::dpt_cmd_t      cmd
);
    import dpt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.in_range ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/dpt_datapath.sv -----
// Datapath of the demand paging translator: configuration, frame table, scan and result.
// Depends on dpt_pkg; driven by dpt_ctrl through command and status structs.
`default_nettype none

module dpt_datapath #(
    parameter int FRAMES = dpt_pkg::FRAMES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [dpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dpt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [dpt_pkg::ADDR_W-1:0]        vaddr,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_of_range,
    output logic                                   page_fault,
    output logic [dpt_pkg::FRAME_OUT_W-1:0]        assigned_frame,
    output logic [dpt_pkg::PHYS_W-1:0]             paddr,
    input  wire dpt_pkg::dpt_cmd_t                 cmd,
    output dpt_pkg::dpt_sts_t                      sts
);
    import dpt_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (IDX_W > FIU_W) ? IDX_W : FIU_W;

    logic                 mode_reg;
    logic [FIU_W-1:0]     fiu_reg;
    logic [ADDR_W-1:0]    base_reg [REGIONS];
    logic [ADDR_W-1:0]    end_reg  [REGIONS];

    logic [ADDR_W-1:0]    addr_reg;
    logic [TICK_W-1:0]    tick_reg;
    logic                 oor_reg;

    logic [FRAMES-1:0]    occ_reg;
    logic [PAGE_W-1:0]    page_mem [FRAMES];
    logic [TICK_W-1:0]    load_mem [FRAMES];
    logic [TICK_W-1:0]    use_mem  [FRAMES];

    logic [CNT_W-1:0]     cnt_reg;
    logic                 eval_valid_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 occ_rd_reg;
    logic [PAGE_W-1:0]    page_rd_reg;
    logic [TICK_W-1:0]    load_rd_reg;
    logic [TICK_W-1:0]    use_rd_reg;

    logic                 hit_found_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 vic_found_reg;
    logic [IDX_W-1:0]     vic_idx_reg;
    logic [TICK_W-1:0]    vic_key_reg;
    logic [PAGE_W-1:0]    vic_page_reg;

    logic                    out_full_reg;
    logic                    out_oor_reg;
    logic                    out_fault_reg;
    logic [FRAME_OUT_W-1:0]  out_frame_reg;
    logic [PHYS_W-1:0]       out_phys_reg;

    logic [PAGE_W-1:0]      cur_page;
    logic [OFFSET_BITS-1:0] cur_offset;
    logic [REGIONS-1:0]     region_hit;
    logic                   scan_active;
    logic [IDX_W-1:0]       rd_idx;
    logic [TICK_W-1:0]      eval_key;
    logic                   eval_hit;
    logic                   eval_free;
    logic                   eval_better;
    logic [IDX_W-1:0]       frame_sel;
    logic                   miss;

    assign cur_page    = addr_reg[ADDR_W-1:OFFSET_BITS];
    assign cur_offset  = addr_reg[OFFSET_BITS-1:0];
    assign scan_active = cmd.scan && (cnt_reg != CNT_W'(FRAMES));
    assign rd_idx      = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        for (int r = 0; r < REGIONS; r++)
        begin
            region_hit[r] = (base_reg[r] <= addr_reg) && (addr_reg < end_reg[r]);
        end
    end

    assign eval_key  = mode_reg ? use_rd_reg : load_rd_reg;
    assign eval_hit  = occ_rd_reg && (page_rd_reg == cur_page);
    assign eval_free = !occ_rd_reg
                       && ((CMP_W'(eval_idx_reg) < CMP_W'(fiu_reg)) || (eval_idx_reg == '0));
    assign eval_better = !vic_found_reg
                         || (eval_key < vic_key_reg)
                         || ((eval_key == vic_key_reg) && (page_rd_reg < vic_page_reg));

    assign miss = !hit_found_reg;

    always_comb
    begin
        priority if (hit_found_reg)
        begin
            frame_sel = hit_idx_reg;
        end
        else if (free_found_reg)
        begin
            frame_sel = free_idx_reg;
        end
        else
        begin
            frame_sel = vic_idx_reg;
        end
    end

    assign sts.in_range  = |region_hit;
    assign sts.scan_done = (cnt_reg == CNT_W'(FRAMES)) && !eval_valid_reg;
    assign sts.out_free  = !out_full_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            fiu_reg  <= FIU_RESET;
            for (int r = 0; r < REGIONS; r++)
            begin
                base_reg[r] <= '0;
                end_reg[r]  <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:         mode_reg    <= cfg_data[0];
                REG_FRAMES:       fiu_reg     <= cfg_data[FIU_W-1:0];
                REG_REGION0_BASE: base_reg[0] <= cfg_data;
                REG_REGION0_END:  end_reg[0]  <= cfg_data;
                REG_REGION1_BASE: base_reg[1] <= cfg_data;
                REG_REGION1_END:  end_reg[1]  <= cfg_data;
                REG_REGION2_BASE: base_reg[2] <= cfg_data;
                REG_REGION2_END:  end_reg[2]  <= cfg_data;
                default:          mode_reg    <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= vaddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
        end
        else if (cmd.accept && (tick_reg != TICK_MAX))
        begin
            tick_reg <= tick_reg + TICK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            eval_valid_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            oor_reg        <= 1'b0;
        end
        else if (cmd.check)
        begin
            cnt_reg        <= '0;
            eval_valid_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            oor_reg        <= !sts.in_range;
        end
        else if (cmd.scan)
        begin
            eval_valid_reg <= scan_active;
            if (scan_active)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (eval_valid_reg)
            begin
                if (eval_hit && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (eval_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (occ_rd_reg && eval_better)
                begin
                    vic_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_active)
        begin
            eval_idx_reg <= rd_idx;
            occ_rd_reg   <= occ_reg[rd_idx];
            page_rd_reg  <= page_mem[rd_idx];
            load_rd_reg  <= load_mem[rd_idx];
            use_rd_reg   <= use_mem[rd_idx];
        end
        if (cmd.scan && eval_valid_reg)
        begin
            if (eval_hit && !hit_found_reg)
            begin
                hit_idx_reg <= eval_idx_reg;
            end
            if (eval_free && !free_found_reg)
            begin
                free_idx_reg <= eval_idx_reg;
            end
            if (occ_rd_reg && eval_better)
            begin
                vic_idx_reg  <= eval_idx_reg;
                vic_key_reg  <= eval_key;
                vic_page_reg <= page_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !oor_reg)
        begin
            use_mem[frame_sel] <= tick_reg;
            if (miss)
            begin
                page_mem[frame_sel] <= cur_page;
                load_mem[frame_sel] <= tick_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.commit && !oor_reg && miss)
        begin
            occ_reg[frame_sel] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_oor_reg <= oor_reg;
            if (oor_reg)
            begin
                out_fault_reg <= 1'b0;
                out_frame_reg <= '0;
                out_phys_reg  <= '0;
            end
            else
            begin
                out_fault_reg <= miss;
                out_frame_reg <= miss ? FRAME_OUT_W'(frame_sel) : '0;
                out_phys_reg  <= PHYS_W'({frame_sel, cur_offset});
            end
        end
    end

    assign out_valid      = out_full_reg;
    assign out_of_range   = out_oor_reg;
    assign page_fault     = out_fault_reg;
    assign assigned_frame = out_frame_reg;
    assign paddr          = out_phys_reg;

endmodule

`default_nettype wire

// ----- sv/demand_paging_translator_unit.sv -----
// Top level of the demand paging translator: controller, datapath and checks.
// Depends on dpt_pkg, dpt_ctrl, dpt_datapath and the shared assertion header.
//
// Translates one virtual address per transfer. An address in none of the three
// configured ranges returns a flagged result without a scan; any other address
// is resolved by a single pass over the frame table through its one read port,
// which finds a hit, the lowest free frame and the replacement victim together.
// A finished result waits in an output register, so the next address can be
// taken while it is pending.
// Configuration writes are taken every cycle and must be issued while idle.
`default_nettype none

`include "demand_paging_translator_unit_defines.svh"

module demand_paging_translator_unit #(
    parameter int FRAMES = dpt_pkg::FRAMES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dpt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [dpt_pkg::ADDR_W-1:0]        vaddr,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_of_range,
    output logic                                   page_fault,
    output logic [dpt_pkg::FRAME_OUT_W-1:0]        assigned_frame,
    output logic [dpt_pkg::PHYS_W-1:0]             paddr
);
    import dpt_pkg::*;

    dpt_cmd_t cmd;
    dpt_sts_t sts;

    assign cfg_ready = 1'b1;

    dpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dpt_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .vaddr          (vaddr),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_of_range   (out_of_range),
        .page_fault     (page_fault),
        .assigned_frame (assigned_frame),
        .paddr          (paddr),
        .cmd            (cmd),
        .sts            (sts)
    );

    `DPT_ASSERT_NOW(a_one_command, clk, rst_n, 1'b1, $onehot0(cmd))
    `DPT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `DPT_ASSERT_NOW(a_commit_has_room, clk, rst_n, cmd.commit, !out_valid || out_ready)
    `DPT_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid)

endmodule

`default_nettype wire

// ----- tb/sv/dpt_translation_checker.sv -----
// Scoreboard for the demand paging translator: follows the configuration, input
// and result channels, predicts each translation and compares it field by field.
// Depends on dpt_pkg for widths and register indexes.
module dpt_translation_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [dpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dpt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic [dpt_pkg::ADDR_W-1:0]        vaddr,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic                              out_of_range,
    input  wire logic                              page_fault,
    input  wire logic [dpt_pkg::FRAME_OUT_W-1:0]   assigned_frame,
    input  wire logic [dpt_pkg::PHYS_W-1:0]        paddr,
    output int                                     error_count,
    output int                                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpt_pkg::*;

    localparam int FRAME_COUNT = FRAMES_DEF;

    typedef struct packed {
        logic                   out_of_range;
        logic                   page_fault;
        logic [FRAME_OUT_W-1:0] frame;
        logic [PHYS_W-1:0]      phys;
    } translation_t;

    logic              replacement_mode;
    logic [FIU_W-1:0]  frames_in_use;
    logic [ADDR_W-1:0] region_base [REGIONS];
    logic [ADDR_W-1:0] region_end [REGIONS];

    logic              resident [FRAME_COUNT];
    logic [PAGE_W-1:0] resident_page [FRAME_COUNT];
    logic [TICK_W-1:0] load_tick [FRAME_COUNT];
    logic [TICK_W-1:0] use_tick [FRAME_COUNT];
    logic [TICK_W-1:0] access_tick;

    translation_t expected_translations[$];

    function automatic translation_t translate(input logic [ADDR_W-1:0] va);
        translation_t      res;
        logic [PAGE_W-1:0] vpn;
        logic [TICK_W-1:0] key;
        logic [TICK_W-1:0] best_key;
        int                slot;
        int                best;
        int                limit;
        bit                in_region;
        bit                hit;
        bit                found;
        res = '0;
        vpn = va[ADDR_W-1:OFFSET_BITS];
        in_region = 1'b0;
        hit = 1'b0;
        found = 1'b0;
        slot = 0;
        best = 0;
        if (access_tick != TICK_MAX)
            access_tick = access_tick + 1'b1;
        for (int r = 0; r < REGIONS; r++)
            if (region_base[r] <= va && va < region_end[r])
                in_region = 1'b1;
        if (!in_region)
        begin
            res.out_of_range = 1'b1;
            return res;
        end
        for (int f = 0; f < FRAME_COUNT && !hit; f++)
            if (resident[f] && resident_page[f] == vpn)
            begin
                slot = f;
                hit = 1'b1;
            end
        if (!hit)
        begin
            if (frames_in_use == 0)
                limit = 1;
            else if (frames_in_use > FRAME_COUNT)
                limit = FRAME_COUNT;
            else
                limit = int'(frames_in_use);
            for (int f = 0; f < limit && !found; f++)
                if (!resident[f])
                begin
                    slot = f;
                    found = 1'b1;
                end
            if (!found)
            begin
                for (int f = 0; f < FRAME_COUNT; f++)
                begin
                    if (!resident[f])
                        continue;
                    if (!found)
                    begin
                        best = f;
                        found = 1'b1;
                        continue;
                    end
                    key = replacement_mode ? use_tick[f] : load_tick[f];
                    best_key = replacement_mode ? use_tick[best] : load_tick[best];
                    if (key < best_key ||
                        (key == best_key && resident_page[f] < resident_page[best]))
                        best = f;
                end
                slot = best;
            end
            resident[slot] = 1'b1;
            resident_page[slot] = vpn;
            load_tick[slot] = access_tick;
            res.page_fault = 1'b1;
            res.frame = FRAME_OUT_W'(slot);
        end
        use_tick[slot] = access_tick;
        res.phys = PHYS_W'(slot * 4096 + int'(va[OFFSET_BITS-1:0]));
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        translation_t want;
        if (!rst_n)
        begin
            replacement_mode = 1'b0;
            frames_in_use = FIU_RESET;
            for (int r = 0; r < REGIONS; r++)
            begin
                region_base[r] = '0;
                region_end[r] = '0;
            end
            for (int f = 0; f < FRAME_COUNT; f++)
                resident[f] = 1'b0;
            access_tick = '0;
            expected_translations.delete();
            error_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:         replacement_mode = cfg_data[0];
                    REG_FRAMES:       frames_in_use = cfg_data[FIU_W-1:0];
                    REG_REGION0_BASE: region_base[0] = cfg_data;
                    REG_REGION0_END:  region_end[0] = cfg_data;
                    REG_REGION1_BASE: region_base[1] = cfg_data;
                    REG_REGION1_END:  region_end[1] = cfg_data;
                    REG_REGION2_BASE: region_base[2] = cfg_data;
                    REG_REGION2_END:  region_end[2] = cfg_data;
                    default:          ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_translations.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %0b %0b %0h %0h",
                             $time, out_of_range, page_fault, assigned_frame, paddr);
                    error_count++;
                end
                else
                begin
                    want = expected_translations.pop_front();
                    check_field("out_of_range", 32'(want.out_of_range), 32'(out_of_range));
                    check_field("page_fault", 32'(want.page_fault), 32'(page_fault));
                    check_field("assigned_frame", 32'(want.frame), 32'(assigned_frame));
                    check_field("paddr", 32'(want.phys), 32'(paddr));
                end
            end
            if (in_valid && in_ready)
                expected_translations.push_back(translate(vaddr));
            outstanding = expected_translations.size();
        end
    end

endmodule

// ----- tb/sv/tb_demand_paging_translator_unit.sv -----
// Testbench top for demand_paging_translator_unit: clock, reset, configuration
// phases, address stimulus and result back-pressure, plus the final verdict.
// Depends on dpt_pkg, the block itself and dpt_translation_checker.
module tb_demand_paging_translator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import dpt_pkg::*;

    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 103;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [ADDR_W-1:0]      vaddr;
    logic                   out_valid;
    logic                   out_ready;
    logic                   out_of_range;
    logic                   page_fault;
    logic [FRAME_OUT_W-1:0] assigned_frame;
    logic [PHYS_W-1:0]      paddr;
    int                     error_count;
    int                     outstanding;

    bit                     quiet;
    int                     hold_requests;
    int                     holds_done;
    int                     usable;
    logic [ADDR_W-1:0]      lo [REGIONS];
    logic [ADDR_W-1:0]      hi [REGIONS];
    logic [ADDR_W-1:0]      page_pool[$];

    demand_paging_translator_unit DUT (.*);

    dpt_translation_checker translation_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #6_000_000;
        $display("demand_paging_translator_unit test failed");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_address(input logic [ADDR_W-1:0] a);
        vaddr <= a;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic mode, input logic [FIU_W-1:0] fiu);
        logic [CFG_DATA_W-1:0] word;
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        word = $urandom;
        word[0] = mode;
        write_reg(REG_MODE, word);
        word = $urandom;
        word[FIU_W-1:0] = fiu;
        write_reg(REG_FRAMES, word);
        write_reg(REG_REGION0_BASE, lo[0]);
        write_reg(REG_REGION0_END, hi[0]);
        write_reg(REG_REGION1_BASE, lo[1]);
        write_reg(REG_REGION1_END, hi[1]);
        write_reg(REG_REGION2_BASE, lo[2]);
        write_reg(REG_REGION2_END, hi[2]);
        cfg_valid <= 1'b0;
        @(negedge clk);
        usable = (fiu == 0) ? 1 : ((fiu > FRAMES_DEF) ? FRAMES_DEF : int'(fiu));
    endtask

    task automatic random_region(input int r);
        logic [ADDR_W-1:0] span;
        lo[r] = $urandom;
        span = $urandom_range(1, 32'h0004_0000);
        hi[r] = ($urandom_range(0, 7) == 0) ? lo[r] : lo[r] + span;
    endtask

    task automatic refill_pool();
        logic [ADDR_W-1:0] a;
        int                r;
        while (page_pool.size() > 8)
            page_pool.delete($urandom_range(0, page_pool.size() - 1));
        repeat (usable + $urandom_range(1, 6))
        begin
            r = $urandom_range(0, REGIONS - 1);
            repeat (REGIONS)
            begin
                if (hi[r] > lo[r])
                    break;
                r = (r + 1) % REGIONS;
            end
            if (hi[r] > lo[r])
                a = lo[r] + $urandom_range(0, hi[r] - lo[r] - 1);
            else
                a = $urandom;
            page_pool.push_back(a);
        end
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        int                roll;
        int                r;
        roll = $urandom_range(0, 99);
        r = $urandom_range(0, REGIONS - 1);
        if (roll < 80 && page_pool.size() != 0)
        begin
            a = page_pool[$urandom_range(0, page_pool.size() - 1)];
            if ($urandom_range(0, 1) == 1)
                a[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom_range(0, 4095));
        end
        else if (roll < 90)
            a = $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0:       a = lo[r];
                1:       a = lo[r] - 1'b1;
                2:       a = hi[r];
                default: a = hi[r] - 1'b1;
            endcase
        end
        return a;
    endfunction

    initial
    begin
        logic [ADDR_W-1:0] fifo_walk [11];
        logic [ADDR_W-1:0] lru_walk [3];
        logic              mode;
        logic [FIU_W-1:0]  fiu;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        vaddr = '0;
        quiet = 1'b0;
        hold_requests = 0;
        usable = FRAMES_DEF;
        fifo_walk = '{32'h0000_0000, 32'h0000_0FFF, 32'h0000_1ABC, 32'hFFFF_E123,
                      32'h0000_0004, 32'h0000_2001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                      32'h0000_3FFF, 32'h0000_4000, 32'h8800_0000};
        lru_walk = '{32'h0000_2000, 32'hFFFF_F000, 32'h0000_0000};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // With every region empty after reset, any address is out of range.
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);

        // Three frames in FIFO mode; the third region has its end below its base.
        lo = '{32'h0000_0000, 32'hFFFF_E000, 32'h9000_0000};
        hi = '{32'h0000_4000, 32'hFFFF_FFFF, 32'h8000_0000};
        apply_settings(1'b0, 7'd3);
        foreach (fifo_walk[i])
            send_address(fifo_walk[i]);

        // A frame count of zero in LRU mode; higher frames keep their pages.
        apply_settings(1'b1, 7'd0);
        foreach (lru_walk[i])
            send_address(lru_walk[i]);
        apply_settings(1'b1, 7'd127);
        send_address(32'h0000_1000);

        for (int p = 0; p < PHASES; p++)
        begin
            quiet = (p >= PHASES - 2);
            if (p == 2)
            begin
                lo[0] = '0;
                hi[0] = '1;
                lo[1] = '1;
                hi[1] = '1;
                random_region(2);
            end
            else
                for (int r = 0; r < REGIONS; r++)
                    random_region(r);
            case (p)
                0:       fiu = 7'd1;
                1:       fiu = 7'd64;
                2:       fiu = 7'd127;
                3:       fiu = 7'd4;
                4:       fiu = 7'd0;
                5:       fiu = 7'd2;
                default: fiu = FIU_W'($urandom_range(1, 12));
            endcase
            mode = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
            apply_settings(mode, fiu);
            refill_pool();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 3 && i == 40)
                    hold_requests++;
                if (p == 5 && i == 50)
                begin
                    in_valid <= 1'b0;
                    while (outstanding != 0)
                        @(negedge clk);
                    @(negedge clk);
                end
                send_address(pick_address());
            end
        end

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("demand_paging_translator_unit test passed");
        else
            $display("demand_paging_translator_unit test failed");
        $finish;
    end

endmodule

// ----- demand_paging_translator_unit.f -----
+incdir+sv
sv/dpt_pkg.sv
sv/dpt_ctrl.sv
sv/dpt_datapath.sv
sv/demand_paging_translator_unit.sv
tb/sv/dpt_translation_checker.sv
tb/sv/tb_demand_paging_translator_unit.sv
